>>> rtl/sfef_pkg.sv
package sfef_pkg;

  // Forest size and field widths
  localparam int MAX_NODES = 1024;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES) + 1;
  localparam int RANK_W    = 4;
  localparam int COST_W    = 16;
  localparam int TOTAL_W   = 26;

  localparam logic [RANK_W-1:0]  RANK_MAX  = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Stream word widths, padded to whole bytes
  localparam int IN_BITS  = 2 * NODE_W + COST_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = TOTAL_W + CNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Register map
  localparam int APB_AW = 3;
  localparam logic REG_NODE_COUNT = 1'b0;

  // One forest entry: rank and parent link kept together
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [NODE_W-1:0] parent;
  } node_entry_t;

  localparam int ENTRY_W = $bits(node_entry_t);

endpackage

>>> rtl/spanning_forest_edge_filter_core.sv
// Channel   | Dir | Word                                              | Handshake
// ----------+-----+---------------------------------------------------+------------------
// s_axis    | in  | tdata: src_node, dst_node, edge_cost (low first)  | tvalid/tready
// m_axis    | out | tdata: tree_total, components; tuser: accepted;   | tvalid/tready
//           |     | tlast: spanning_done                              |
// apb       | in  | node_count at byte address 0                      | psel/penable
//
// One edge at a time. Each accepted edge is walked from each endpoint in turn: a root
// search, then, unless the endpoint is its own root, a relink pass that points the path
// at the root, one forest RAM access per cycle; then the union, plus a rank update when
// two roots of equal rank are joined. Out-of-range edges skip straight to the result.
// After reset and after every node_count write the forest RAM is swept, one entry
// per cycle, over all MAX_NODES entries; no edge is taken during the sweep.
// A finished result sits in the output register while the next edge is taken.
module spanning_forest_edge_filter_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // edge input
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [sfef_pkg::IN_W-1:0]    s_axis_tdata_i,   // src_node, dst_node, edge_cost
  // result output
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [sfef_pkg::OUT_W-1:0]   m_axis_tdata_o,   // tree_total, components
  output logic                         m_axis_tuser_o,   // accepted
  output logic                         m_axis_tlast_o,   // spanning_done
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfef_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int NODE_W  = sfef_pkg::NODE_W;
  localparam int CNT_W   = sfef_pkg::CNT_W;
  localparam int RANK_W  = sfef_pkg::RANK_W;
  localparam int COST_W  = sfef_pkg::COST_W;
  localparam int TOTAL_W = sfef_pkg::TOTAL_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FIND  = 3'd1;
  localparam logic [2:0] ST_COMP  = 3'd2;
  localparam logic [2:0] ST_NEXT  = 3'd3;
  localparam logic [2:0] ST_UNION = 3'd4;
  localparam logic [2:0] ST_RANK  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]          state_q, state_d;
  logic                phase_q, phase_d;     // 0: source walk, 1: destination walk
  logic [NODE_W-1:0]   walk_q, walk_d;
  logic [NODE_W-1:0]   start_q, start_d;
  logic [NODE_W-1:0]   root1_q, root1_d, root2_q, root2_d;
  logic [RANK_W-1:0]   rank1_q, rank1_d, rank2_q, rank2_d;
  logic [NODE_W-1:0]   dst_q, dst_d;
  logic [COST_W-1:0]   cost_q, cost_d;
  logic                acc_q, acc_d;

  logic [CNT_W-1:0]    node_cnt_q, node_cnt_d;
  logic [CNT_W-1:0]    set_cnt_q, set_cnt_d;
  logic [TOTAL_W-1:0]  total_q, total_d;

  logic                clr_busy_q, clr_busy_d;
  logic [NODE_W-1:0]   clr_idx_q, clr_idx_d;

  logic                out_valid_q, out_valid_d;
  logic                out_acc_q, out_acc_d;
  logic [TOTAL_W-1:0]  out_total_q, out_total_d;
  logic [CNT_W-1:0]    out_cnt_q, out_cnt_d;

  // Forest RAM ports
  logic                  ram_we;
  logic [NODE_W-1:0]     ram_waddr;
  sfef_pkg::node_entry_t ram_wentry;
  logic [NODE_W-1:0]     ram_raddr;
  logic [sfef_pkg::ENTRY_W-1:0] ram_rdata;
  sfef_pkg::node_entry_t rd_ent;

  logic                in_acc;
  logic                cfg_wr;
  logic [CNT_W-1:0]    n_eff, new_n_eff;
  logic [CNT_W-1:0]    new_cnt;
  logic                in_range;
  logic [NODE_W-1:0]   in_src, in_dst;
  logic [COST_W-1:0]   in_cost;
  logic [NODE_W-1:0]   cur_root;
  logic [TOTAL_W:0]    sum_ext;

  sfef_ram #(
    .WIDTH (sfef_pkg::ENTRY_W),
    .DEPTH (sfef_pkg::MAX_NODES)
  ) u_forest (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wentry),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_ent = sfef_pkg::node_entry_t'(ram_rdata);

  // Input word unpacking
  assign in_src  = s_axis_tdata_i[NODE_W-1:0];
  assign in_dst  = s_axis_tdata_i[2*NODE_W-1:NODE_W];
  assign in_cost = s_axis_tdata_i[2*NODE_W+COST_W-1:2*NODE_W];

  assign s_axis_tready_o = (state_q == ST_IDLE) && !clr_busy_q;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // APB: always ready, single register
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (paddr[2] == sfef_pkg::REG_NODE_COUNT);
  assign prdata  = (paddr[2] == sfef_pkg::REG_NODE_COUNT) ?
                   {{(32-CNT_W){1'b0}}, node_cnt_q} : 32'd0;
  assign new_cnt = pwdata[CNT_W-1:0];

  // Effective node count: clamp to 1..MAX_NODES
  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] r;
    r = n;
    if (n == '0) begin
      r = CNT_W'(1);
    end else if (n > CNT_W'(sfef_pkg::MAX_NODES)) begin
      r = CNT_W'(sfef_pkg::MAX_NODES);
    end
    return r;
  endfunction

  assign n_eff     = clamp_cnt(node_cnt_q);
  assign new_n_eff = clamp_cnt(new_cnt);
  assign in_range  = ({1'b0, in_src} < n_eff) && ({1'b0, in_dst} < n_eff);
  assign cur_root  = phase_q ? root2_q : root1_q;
  assign sum_ext   = {1'b0, total_q} + {{(TOTAL_W+1-COST_W){1'b0}}, cost_q};

  // Sequencer and forest access
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    walk_d     = walk_q;
    start_d    = start_q;
    root1_d    = root1_q;
    root2_d    = root2_q;
    rank1_d    = rank1_q;
    rank2_d    = rank2_q;
    dst_d      = dst_q;
    cost_d     = cost_q;
    acc_d      = acc_q;
    node_cnt_d = node_cnt_q;
    set_cnt_d  = set_cnt_q;
    total_d    = total_q;
    clr_busy_d = clr_busy_q;
    clr_idx_d  = clr_idx_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_acc_d   = out_acc_q;
    out_total_d = out_total_q;
    out_cnt_d   = out_cnt_q;
    ram_we      = 1'b0;
    ram_waddr   = walk_q;
    ram_wentry  = '{rank: rd_ent.rank, parent: cur_root};
    ram_raddr   = walk_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          dst_d  = in_dst;
          cost_d = in_cost;
          if (in_range) begin
            phase_d   = 1'b0;
            walk_d    = in_src;
            start_d   = in_src;
            ram_raddr = in_src;
            state_d   = ST_FIND;
          end else begin
            acc_d   = 1'b0;
            state_d = ST_DONE;
          end
        end
      end
      // follow parent links until an entry points to itself
      ST_FIND: begin
        if (rd_ent.parent == walk_q) begin
          if (phase_q) begin
            root2_d = walk_q;
            rank2_d = rd_ent.rank;
          end else begin
            root1_d = walk_q;
            rank1_d = rd_ent.rank;
          end
          if (start_q == walk_q) begin
            state_d = ST_NEXT;
          end else begin
            walk_d    = start_q;
            ram_raddr = start_q;
            state_d   = ST_COMP;
          end
        end else begin
          walk_d    = rd_ent.parent;
          ram_raddr = rd_ent.parent;
        end
      end
      // relink each node on the path straight to the root
      ST_COMP: begin
        ram_we     = 1'b1;
        ram_waddr  = walk_q;
        ram_wentry = '{rank: rd_ent.rank, parent: cur_root};
        if (rd_ent.parent == cur_root) begin
          state_d = ST_NEXT;
        end else begin
          walk_d    = rd_ent.parent;
          ram_raddr = rd_ent.parent;
        end
      end
      ST_NEXT: begin
        if (phase_q) begin
          state_d = ST_UNION;
        end else begin
          phase_d   = 1'b1;
          walk_d    = dst_q;
          start_d   = dst_q;
          ram_raddr = dst_q;
          state_d   = ST_FIND;
        end
      end
      // union by rank; ties hang the destination root under the source root
      ST_UNION: begin
        if (root1_q == root2_q) begin
          acc_d   = 1'b0;
          state_d = ST_DONE;
        end else begin
          acc_d  = 1'b1;
          ram_we = 1'b1;
          if (rank2_q > rank1_q) begin
            ram_waddr  = root1_q;
            ram_wentry = '{rank: rank1_q, parent: root2_q};
            state_d    = ST_DONE;
          end else begin
            ram_waddr  = root2_q;
            ram_wentry = '{rank: rank2_q, parent: root1_q};
            state_d    = (rank1_q == rank2_q) ? ST_RANK : ST_DONE;
          end
          if (set_cnt_q > CNT_W'(1)) begin
            set_cnt_d = set_cnt_q - CNT_W'(1);
          end
          total_d = sum_ext[TOTAL_W] ? sfef_pkg::TOTAL_MAX : sum_ext[TOTAL_W-1:0];
        end
      end
      ST_RANK: begin
        ram_we     = 1'b1;
        ram_waddr  = root1_q;
        ram_wentry = '{rank: (rank1_q == sfef_pkg::RANK_MAX) ? rank1_q
                                                            : rank1_q + RANK_W'(1),
                       parent: root1_q};
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_acc_d   = acc_q;
          out_total_d = total_q;
          out_cnt_d   = set_cnt_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // forest sweep: every entry back to itself with rank zero
    if (clr_busy_q) begin
      ram_we     = 1'b1;
      ram_waddr  = clr_idx_q;
      ram_wentry = '{rank: '0, parent: clr_idx_q};
      clr_idx_d  = clr_idx_q + NODE_W'(1);
      if (clr_idx_q == '1) begin
        clr_busy_d = 1'b0;
      end
    end

    // node_count write restarts the forest
    if (cfg_wr) begin
      node_cnt_d = new_cnt;
      set_cnt_d  = new_n_eff;
      total_d    = '0;
      clr_busy_d = 1'b1;
      clr_idx_d  = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      node_cnt_q  <= CNT_W'(sfef_pkg::MAX_NODES);
      set_cnt_q   <= CNT_W'(sfef_pkg::MAX_NODES);
      total_q     <= '0;
      clr_busy_q  <= 1'b1;
      clr_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      node_cnt_q  <= node_cnt_d;
      set_cnt_q   <= set_cnt_d;
      total_q     <= total_d;
      clr_busy_q  <= clr_busy_d;
      clr_idx_q   <= clr_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk_i) begin
    phase_q     <= phase_d;
    walk_q      <= walk_d;
    start_q     <= start_d;
    root1_q     <= root1_d;
    root2_q     <= root2_d;
    rank1_q     <= rank1_d;
    rank2_q     <= rank2_d;
    dst_q       <= dst_d;
    cost_q      <= cost_d;
    acc_q       <= acc_d;
    out_acc_q   <= out_acc_d;
    out_total_q <= out_total_d;
    out_cnt_q   <= out_cnt_d;
  end

  // Result word
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(sfef_pkg::OUT_W-sfef_pkg::OUT_BITS){1'b0}},
                            out_cnt_q, out_total_q};
  assign m_axis_tuser_o  = out_acc_q;
  assign m_axis_tlast_o  = (out_cnt_q == CNT_W'(1));

endmodule

>>> rtl/sfef_ram.sv
module sfef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
